FILE: sv/positional_circular_list_top_macros.svh
// Assertion macros shared by the checker. Each expects clk and arst_n in scope.
`ifndef POSITIONAL_CIRCULAR_LIST_TOP_MACROS_SVH
`define POSITIONAL_CIRCULAR_LIST_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional list check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional list check failed");

`endif

FILE: sv/pcl_pkg.sv
`timescale 1ns / 1ps
package pcl_pkg;

	// Wide enough for a count of up to 64 entries.
	localparam int CNT_W = 7;

	typedef enum logic [2:0] {
		ACT_INS_FIRST = 3'd0,
		ACT_INS_LAST  = 3'd1,
		ACT_INS_POS   = 3'd2,
		ACT_DEL_FIRST = 3'd3,
		ACT_DEL_LAST  = 3'd4,
		ACT_DEL_POS   = 3'd5,
		ACT_READ      = 3'd6,
		ACT_NOP       = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_FULL   = 2'd1,
		STS_EMPTY  = 2'd2,
		STS_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2,
		OP_ROT  = 2'd3
	} cell_op_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
	} cell_ctl_t;

endpackage

FILE: sv/pcl_cell.sv
`timescale 1ns / 1ps
module pcl_cell #(
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  pcl_pkg::cell_ctl_t      ctl,
	input  logic signed [31:0]      value,
	input  logic signed [31:0]      left_d,
	input  logic signed [31:0]      right_d,
	input  logic signed [31:0]      head_d,
	output logic signed [31:0]      data_q
);

	localparam logic [pcl_pkg::CNT_W-1:0] IDX_C = pcl_pkg::CNT_W'(IDX);
	localparam logic [pcl_pkg::CNT_W-1:0] IDX_N = pcl_pkg::CNT_W'(IDX + 1);

	logic signed [31:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			pcl_pkg::OP_INS: begin
				if (IDX_C == ctl.idx) begin
					data_d = value;
				end else if (IDX_C > ctl.idx && IDX_C <= ctl.cnt) begin
					data_d = left_d;
				end
			end
			pcl_pkg::OP_DEL: begin
				if (IDX_C >= ctl.idx && IDX_N < ctl.cnt) begin
					data_d = right_d;
				end
			end
			pcl_pkg::OP_ROT: begin
				// The row turns by one so the front entry wraps to the tail.
				if (IDX_N < ctl.cnt) begin
					data_d = right_d;
				end else if (IDX_N == ctl.cnt) begin
					data_d = head_d;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

FILE: sv/positional_circular_list_top.sv
`timescale 1ns / 1ps
// Inserts and deletes are registered: the result register loads on the edge of the request.
// A read out gives one result per entry, one per cycle while results are taken, front first, from the read state.
// Edit throughput is one request per cycle while results are taken; the cell row shifts once.
// A read out holds the input off while the row rotates once around.
// Reset clears the entry count, state and result valid; cell contents stay undefined.
module positional_circular_list_top #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [31:0] value,
	input  logic [5:0]         position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [5:0]         count,
	output logic signed [31:0] item,
	output logic               last
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = CW + 7;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [5:0]         count_q;
	logic signed [31:0] item_q;
	logic               last_q;

	logic signed [31:0] cell_q [CAPACITY];
	pcl_pkg::cell_ctl_t ctl;

	logic               out_free;
	logic               accept;
	logic               full;
	logic               empty;
	logic [CMPW-1:0]    pos_c;
	logic [CMPW-1:0]    cnt_c;
	pcl_pkg::action_t   act;
	pcl_pkg::status_t   dec_sts;
	pcl_pkg::cell_op_t  dec_op;
	logic [CW-1:0]      dec_idx;
	logic [CW-1:0]      dec_cnt;
	logic [CW+5:0]      dec_cnt_ext;
	logic [CW+5:0]      cnt_ext;
	logic               rd_last;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	assign full    = (cnt_q == CW'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign pos_c   = CMPW'(position);
	assign cnt_c   = CMPW'(cnt_q);
	assign act     = pcl_pkg::action_t'(action);
	assign rd_last = (rd_q == cnt_q - CW'(1));

	always_comb begin
		dec_sts = pcl_pkg::STS_OK;
		dec_op  = pcl_pkg::OP_HOLD;
		dec_idx = '0;
		dec_cnt = cnt_q;
		case (act)
			pcl_pkg::ACT_INS_FIRST, pcl_pkg::ACT_INS_LAST: begin
				if (full) begin
					dec_sts = pcl_pkg::STS_FULL;
				end else begin
					dec_op  = pcl_pkg::OP_INS;
					dec_idx = (act == pcl_pkg::ACT_INS_LAST) ? cnt_q : '0;
					dec_cnt = cnt_q + CW'(1);
				end
			end
			pcl_pkg::ACT_INS_POS: begin
				// Position is checked before fullness.
				if (position == 6'd0 || pos_c > cnt_c + CMPW'(1)) begin
					dec_sts = pcl_pkg::STS_BADPOS;
				end else if (full) begin
					dec_sts = pcl_pkg::STS_FULL;
				end else begin
					dec_op  = pcl_pkg::OP_INS;
					dec_idx = CW'(position - 6'd1);
					dec_cnt = cnt_q + CW'(1);
				end
			end
			pcl_pkg::ACT_DEL_FIRST, pcl_pkg::ACT_DEL_LAST: begin
				if (empty) begin
					dec_sts = pcl_pkg::STS_EMPTY;
				end else begin
					dec_op  = pcl_pkg::OP_DEL;
					dec_idx = (act == pcl_pkg::ACT_DEL_LAST) ? cnt_q - CW'(1) : '0;
					dec_cnt = cnt_q - CW'(1);
				end
			end
			pcl_pkg::ACT_DEL_POS: begin
				if (empty) begin
					dec_sts = pcl_pkg::STS_EMPTY;
				end else if (position == 6'd0 || pos_c > cnt_c) begin
					dec_sts = pcl_pkg::STS_BADPOS;
				end else begin
					dec_op  = pcl_pkg::OP_DEL;
					dec_idx = CW'(position - 6'd1);
					dec_cnt = cnt_q - CW'(1);
				end
			end
			pcl_pkg::ACT_READ: begin
				if (empty) begin
					dec_sts = pcl_pkg::STS_EMPTY;
				end
			end
			default: begin
				dec_sts = pcl_pkg::STS_OK;
			end
		endcase
	end

	assign dec_cnt_ext = (CW + 6)'(dec_cnt);
	assign cnt_ext     = (CW + 6)'(cnt_q);

	always_comb begin
		ctl.op  = pcl_pkg::OP_HOLD;
		ctl.idx = pcl_pkg::CNT_W'(dec_idx);
		ctl.cnt = pcl_pkg::CNT_W'(cnt_q);
		if (state_q == ST_READ && out_free) begin
			ctl.op = pcl_pkg::OP_ROT;
		end else if (accept) begin
			ctl.op = dec_op;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;

		if (i == 0) begin : g_head
			assign left_d = cell_q[0];
		end else begin : g_body
			assign left_d = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_d = cell_q[i];
		end else begin : g_mid
			assign right_d = cell_q[i+1];
		end

		pcl_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.value  (value),
			.left_d (left_d),
			.right_d(right_d),
			.head_d (cell_q[0]),
			.data_q (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
			status_q    <= pcl_pkg::STS_OK;
			count_q     <= '0;
			item_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						if (act == pcl_pkg::ACT_READ && !empty) begin
							state_q <= ST_READ;
							rd_q    <= '0;
						end else begin
							cnt_q       <= dec_cnt;
							out_valid_q <= 1'b1;
							status_q    <= dec_sts;
							count_q     <= dec_cnt_ext[5:0];
							item_q      <= '0;
							last_q      <= 1'b1;
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						// The front cell is emitted while the row rotates behind it.
						out_valid_q <= 1'b1;
						status_q    <= pcl_pkg::STS_OK;
						count_q     <= cnt_ext[5:0];
						item_q      <= cell_q[0];
						last_q      <= rd_last;
						rd_q        <= rd_q + CW'(1);
						if (rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign count     = count_q;
	assign item      = item_q;
	assign last      = last_q;

endmodule

FILE: sv/pcl_checker.sv
`timescale 1ns / 1ps
`include "positional_circular_list_top_macros.svh"
module pcl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [5:0]         count,
	input logic signed [31:0] item,
	input logic               last
);

	// A request is only taken when the result register can be freed in the same cycle.
	`PCL_ASSERT_NOW(a_ready_needs_room, in_ready, !out_valid || out_ready)

	// Any error result ends its request.
	`PCL_ASSERT_NOW(a_error_is_last, out_valid && status != pcl_pkg::STS_OK, last)

	// An empty report always shows an empty list and no entry.
	`PCL_ASSERT_NOW(a_empty_count, out_valid && status == pcl_pkg::STS_EMPTY,
		count == 6'd0 && item == 32'sd0)

	// A stalled result holds.
	`PCL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(count) && $stable(item) && $stable(last))

endmodule

bind positional_circular_list_top pcl_checker u_pcl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status   (status),
	.count    (count),
	.item     (item),
	.last     (last)
);
